// ----- rtl/stack_machine_word_executor_assert.svh -----
// ----------------------------------------------------------------------------
// stack machine word executor assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_WORD_EXECUTOR_ASSERT_SVH
`define STACK_MACHINE_WORD_EXECUTOR_ASSERT_SVH

// same-cycle implication
`define SMWE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smwe assertion failed");

// next-cycle implication
`define SMWE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smwe assertion failed");

`endif

// ----- rtl/smwe_pkg.sv -----
// ----------------------------------------------------------------------------
// smwe_pkg
// types, codes and decode helpers for the stack machine word executor
// ----------------------------------------------------------------------------
package smwe_pkg;

    localparam int STK_CELLS   = 64;
    localparam int CELL_BITS   = 32;
    localparam int FIELD_BITS  = 32;
    localparam int SP_W        = $clog2(STK_CELLS + 1);
    localparam int ADDR_W      = $clog2(STK_CELLS);
    localparam int FUNC_W      = 5;
    localparam int DIV_CNT_W   = $clog2(CELL_BITS);

    localparam int CHAR_CR    = 10;
    localparam int CHAR_SPACE = 32;

    typedef logic [CELL_BITS-1:0] t_cell;
    typedef logic [SP_W-1:0]      t_sp;

    typedef enum logic [FUNC_W-1:0] {
        F_PUSH   = 5'd0,
        F_ADD    = 5'd1,
        F_SUB    = 5'd2,
        F_MUL    = 5'd3,
        F_DIV    = 5'd4,
        F_MOD    = 5'd5,
        F_NEGATE = 5'd6,
        F_DUP    = 5'd7,
        F_DROP   = 5'd8,
        F_SWAP   = 5'd9,
        F_OVER   = 5'd10,
        F_ROT    = 5'd11,
        F_DOT    = 5'd12,
        F_EMIT   = 5'd13,
        F_CR     = 5'd14,
        F_SPACE  = 5'd15,
        F_EQ     = 5'd16,
        F_LT     = 5'd17,
        F_GT     = 5'd18,
        F_AND    = 5'd19,
        F_OR     = 5'd20,
        F_NOT    = 5'd21
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_DIVZ  = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_NUM  = 2'd1,
        K_CHAR = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_ADDR,
        S_RD_DATA,
        S_EXEC,
        S_DIV,
        S_WR,
        S_TOP_ADDR,
        S_TOP_DATA,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       rd_issue;
        logic       rd_latch;
        logic       exec;
        logic       wr;
        logic       top_issue;
        logic       top_latch;
        logic       load_out;
        logic [1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [1:0] n_rd;
        logic [1:0] n_wr;
        logic       div_run;
        logic       div_done;
    } t_sts;

    typedef struct packed {
        logic [1:0] n_rd;
        t_status    err;
        t_sp        err_sp;
    } t_dec;

    // operand count and early underflow / overflow check
    function automatic t_dec decode(input t_func func, input t_sp sp);
        t_dec d;
        logic full;
        full     = (sp >= SP_W'(STK_CELLS));
        d.n_rd   = 2'd0;
        d.err    = ST_OK;
        d.err_sp = sp;
        unique case (func)
            F_ADD, F_SUB, F_MUL, F_DIV, F_MOD, F_EQ, F_LT, F_GT, F_AND, F_OR: begin
                if (sp < SP_W'(2)) begin
                    d.err    = ST_UNDER;
                    d.err_sp = '0;
                end else begin
                    d.n_rd = 2'd2;
                end
            end
            F_NEGATE, F_NOT, F_DOT, F_EMIT: begin
                if (sp == '0) d.err = ST_UNDER;
                else          d.n_rd = 2'd1;
            end
            F_DUP: begin
                if (sp == '0)  d.err = ST_UNDER;
                else if (full) d.err = ST_OVER;
                else           d.n_rd = 2'd1;
            end
            F_DROP: begin
                if (sp == '0) d.err = ST_UNDER;
            end
            F_SWAP: begin
                if (sp < SP_W'(2)) d.err = ST_UNDER;
                else               d.n_rd = 2'd2;
            end
            F_OVER: begin
                if (sp < SP_W'(2)) d.err = ST_UNDER;
                else if (full)     d.err = ST_OVER;
                else               d.n_rd = 2'd2;
            end
            F_ROT: begin
                if (sp < SP_W'(3)) d.err = ST_UNDER;
                else               d.n_rd = 2'd3;
            end
            F_PUSH: begin
                if (full) d.err = ST_OVER;
            end
            default: begin
                d.n_rd = 2'd0;
            end
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/smwe_div.sv -----
// ----------------------------------------------------------------------------
// smwe_div
// restoring signed divider, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
module smwe_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  smwe_pkg::t_cell  i_dividend,
    input  smwe_pkg::t_cell  i_divisor,
    output logic             o_done,
    output smwe_pkg::t_cell  o_quotient,
    output smwe_pkg::t_cell  o_remainder
);
    import smwe_pkg::*;

    t_cell                r_rem;
    t_cell                r_quo;
    t_cell                r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic                 r_neg_q;
    logic                 r_neg_r;
    logic [CELL_BITS:0]   shifted;
    logic [CELL_BITS:0]   diff;

    assign shifted = {r_rem, r_quo[CELL_BITS-1]};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo   <= i_dividend[CELL_BITS-1] ? -i_dividend : i_dividend;
            r_den   <= i_divisor[CELL_BITS-1] ? -i_divisor : i_divisor;
            r_rem   <= '0;
            r_cnt   <= DIV_CNT_W'(CELL_BITS - 1);
            r_neg_q <= i_dividend[CELL_BITS-1] ^ i_divisor[CELL_BITS-1];
            r_neg_r <= i_dividend[CELL_BITS-1];
        end else if (r_busy) begin
            if (!diff[CELL_BITS]) begin
                r_rem <= diff[CELL_BITS-1:0];
                r_quo <= {r_quo[CELL_BITS-2:0], 1'b1};
            end else begin
                r_rem <= shifted[CELL_BITS-1:0];
                r_quo <= {r_quo[CELL_BITS-2:0], 1'b0};
            end
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_neg_q ? -r_quo : r_quo;
    assign o_remainder = r_neg_r ? -r_rem : r_rem;

endmodule

// ----- rtl/smwe_dpath.sv -----
// ----------------------------------------------------------------------------
// smwe_dpath
// stack memory, stack pointer, operand registers, alu and result registers
// ----------------------------------------------------------------------------
module smwe_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  smwe_pkg::t_cmd                 i_cmd,
    output smwe_pkg::t_sts                 o_sts,
    input  logic [smwe_pkg::FUNC_W-1:0]    i_func,
    input  logic signed [smwe_pkg::FIELD_BITS-1:0] i_literal,
    output logic [1:0]                     o_status,
    output logic [1:0]                     o_out_kind,
    output logic signed [smwe_pkg::FIELD_BITS-1:0] o_out_value,
    output logic [smwe_pkg::SP_W-1:0]      o_depth,
    output logic signed [smwe_pkg::FIELD_BITS-1:0] o_top_value
);
    import smwe_pkg::*;

    t_cell             mem [STK_CELLS];
    t_cell             r_rd_data;
    t_func             r_func;
    t_cell             r_lit;
    t_sp               r_sp;
    t_cell             r_op [3];
    t_cell             r_res;
    t_status           r_status;
    t_kind             r_kind;
    t_cell             r_value;
    t_sp               r_new_sp;
    t_sp               r_wbase;
    logic [1:0]        r_nwr;
    t_cell             r_top;

    logic [1:0]        r_o_status;
    logic [1:0]        r_o_kind;
    t_cell             r_o_value;
    t_sp               r_o_depth;
    t_cell             r_o_top;

    t_dec              dec;
    t_cell             a;
    t_cell             b;
    logic              is_div;
    logic              div_run;
    t_cell             n_res;
    t_status           n_status;
    t_kind             n_kind;
    t_cell             n_value;
    t_sp               n_new_sp;
    t_sp               n_wbase;
    logic [1:0]        n_nwr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    t_cell             wr_data;
    logic              div_done;
    t_cell             div_q;
    t_cell             div_r;

    assign dec    = decode(r_func, r_sp);
    assign b      = r_op[0];
    assign a      = (r_func == F_NEGATE || r_func == F_NOT || r_func == F_DOT ||
                     r_func == F_EMIT) ? r_op[0] : r_op[1];
    assign is_div = (r_func == F_DIV) || (r_func == F_MOD);
    assign div_run = is_div && (dec.err == ST_OK) && (b != '0);

    // result of the primitive once its operands are in
    always_comb begin
        n_res    = '0;
        n_status = dec.err;
        n_kind   = K_NONE;
        n_value  = '0;
        n_new_sp = dec.err_sp;
        n_wbase  = r_sp;
        n_nwr    = 2'd0;
        if (dec.err == ST_OK) begin
            unique case (r_func)
                F_ADD, F_SUB, F_MUL, F_EQ, F_LT, F_GT, F_AND, F_OR, F_DIV, F_MOD: begin
                    n_new_sp = r_sp - SP_W'(1);
                    n_wbase  = r_sp - SP_W'(2);
                    n_nwr    = 2'd1;
                    unique case (r_func)
                        F_ADD:   n_res = a + b;
                        F_SUB:   n_res = a - b;
                        F_MUL:   n_res = CELL_BITS'(a * b);
                        F_EQ:    n_res = (a == b) ? '1 : '0;
                        F_LT:    n_res = ($signed(a) < $signed(b)) ? '1 : '0;
                        F_GT:    n_res = ($signed(b) < $signed(a)) ? '1 : '0;
                        F_AND:   n_res = a & b;
                        F_OR:    n_res = a | b;
                        default: n_res = '0;
                    endcase
                    if (is_div && b == '0) begin
                        n_status = ST_DIVZ;
                        n_new_sp = r_sp - SP_W'(2);
                        n_nwr    = 2'd0;
                    end
                end
                F_NEGATE, F_NOT: begin
                    n_res    = (r_func == F_NEGATE) ? -a : ~a;
                    n_new_sp = r_sp;
                    n_wbase  = r_sp - SP_W'(1);
                    n_nwr    = 2'd1;
                end
                F_DOT: begin
                    n_kind   = K_NUM;
                    n_value  = a;
                    n_new_sp = r_sp - SP_W'(1);
                end
                F_EMIT: begin
                    n_kind   = K_CHAR;
                    n_value  = CELL_BITS'(a[7:0]);
                    n_new_sp = r_sp - SP_W'(1);
                end
                F_CR: begin
                    n_kind  = K_CHAR;
                    n_value = CELL_BITS'(CHAR_CR);
                end
                F_SPACE: begin
                    n_kind  = K_CHAR;
                    n_value = CELL_BITS'(CHAR_SPACE);
                end
                F_PUSH, F_DUP, F_OVER: begin
                    n_new_sp = r_sp + SP_W'(1);
                    n_nwr    = 2'd1;
                end
                F_DROP: begin
                    n_new_sp = r_sp - SP_W'(1);
                end
                F_SWAP: begin
                    n_wbase = r_sp - SP_W'(2);
                    n_nwr   = 2'd2;
                end
                F_ROT: begin
                    n_wbase = r_sp - SP_W'(3);
                    n_nwr   = 2'd3;
                end
                default: begin
                    n_nwr = 2'd0;
                end
            endcase
        end
    end

    // cell written at slot idx of the write-back sweep
    always_comb begin
        case (r_func)
            F_PUSH:  wr_data = r_lit;
            F_DUP:   wr_data = r_op[0];
            F_OVER:  wr_data = r_op[1];
            F_SWAP:  wr_data = (i_cmd.idx == 2'd0) ? r_op[0] : r_op[1];
            F_ROT: begin
                case (i_cmd.idx)
                    2'd0:    wr_data = r_op[1];
                    2'd1:    wr_data = r_op[0];
                    default: wr_data = r_op[2];
                endcase
            end
            default: wr_data = r_res;
        endcase
    end

    assign wr_addr = ADDR_W'(r_wbase + SP_W'(i_cmd.idx));
    assign rd_addr = i_cmd.top_issue ? ADDR_W'(r_new_sp - SP_W'(1))
                                     : ADDR_W'(r_sp - SP_W'(1) - SP_W'(i_cmd.idx));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) mem[wr_addr] <= wr_data;
        if (i_cmd.rd_issue || i_cmd.top_issue) r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_cmd.top_issue) begin
            r_sp <= r_new_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= t_func'(i_func);
            r_lit  <= CELL_BITS'(i_literal);
        end
        if (i_cmd.rd_latch) r_op[i_cmd.idx] <= r_rd_data;
        if (i_cmd.exec) begin
            r_res    <= n_res;
            r_status <= n_status;
            r_kind   <= n_kind;
            r_value  <= n_value;
            r_new_sp <= n_new_sp;
            r_wbase  <= n_wbase;
            r_nwr    <= n_nwr;
        end else if (div_done) begin
            r_res <= (r_func == F_MOD) ? div_r : div_q;
        end
        if (i_cmd.top_latch) r_top <= (r_sp == '0) ? '0 : r_rd_data;
        if (i_cmd.load_out) begin
            r_o_status <= r_status;
            r_o_kind   <= r_kind;
            r_o_value  <= r_value;
            r_o_depth  <= r_sp;
            r_o_top    <= r_top;
        end
    end

    smwe_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.exec && div_run),
        .i_dividend  (a),
        .i_divisor   (b),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    assign o_sts.n_rd     = dec.n_rd;
    assign o_sts.n_wr     = r_nwr;
    assign o_sts.div_run  = div_run;
    assign o_sts.div_done = div_done;

    assign o_status    = r_o_status;
    assign o_out_kind  = r_o_kind;
    assign o_out_value = FIELD_BITS'(signed'(r_o_value));
    assign o_depth     = r_o_depth;
    assign o_top_value = FIELD_BITS'(signed'(r_o_top));

endmodule

// ----- rtl/smwe_ctrl.sv -----
// ----------------------------------------------------------------------------
// smwe_ctrl
// sequencer: operand reads, execute, divide wait, write-back, top refresh
// ----------------------------------------------------------------------------
`include "stack_machine_word_executor_assert.svh"

module smwe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    output smwe_pkg::t_cmd o_cmd,
    input  smwe_pkg::t_sts i_sts
);
    import smwe_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_k;
    logic [1:0] n_k;
    logic       r_o_valid;
    logic       out_free;

    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_RD_ADDR;
                    n_k     = 2'd0;
                end
            end
            S_RD_ADDR: begin
                if (r_k == i_sts.n_rd) n_state = S_EXEC;
                else                   n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                n_state = S_RD_ADDR;
                n_k     = r_k + 2'd1;
            end
            S_EXEC: begin
                n_state = i_sts.div_run ? S_DIV : S_WR;
                n_k     = 2'd0;
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_WR;
            end
            S_WR: begin
                if (r_k == i_sts.n_wr) n_state = S_TOP_ADDR;
                else                   n_k     = r_k + 2'd1;
            end
            S_TOP_ADDR: n_state = S_TOP_DATA;
            S_TOP_DATA: n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_cmd.idx = r_k;
        unique case (r_state)
            S_IDLE:     o_cmd.accept    = i_valid;
            S_RD_ADDR:  o_cmd.rd_issue  = (r_k != i_sts.n_rd);
            S_RD_DATA:  o_cmd.rd_latch  = 1'b1;
            S_EXEC:     o_cmd.exec      = 1'b1;
            S_WR:       o_cmd.wr        = (r_k != i_sts.n_wr);
            S_TOP_ADDR: o_cmd.top_issue = 1'b1;
            S_TOP_DATA: o_cmd.top_latch = 1'b1;
            S_DONE:     o_cmd.load_out  = out_free;
            default:    o_cmd.idx       = r_k;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_k       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (o_cmd.load_out)  r_o_valid <= 1'b1;
            else if (!i_stall)   r_o_valid <= 1'b0;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_o_valid;

    `SMWE_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, r_state == S_IDLE && i_valid, r_state == S_RD_ADDR)
    `SMWE_ASSERT_IMPLY(a_div_done_waited, i_clk, i_rst_n, i_sts.div_done, r_state == S_DIV)
    `SMWE_ASSERT_IMPLY(a_result_from_done, i_clk, i_rst_n, $rose(r_o_valid), $past(r_state) == S_DONE)

endmodule

// ----- rtl/stack_machine_word_executor.sv -----
// ----------------------------------------------------------------------------
// stack_machine_word_executor
// forth data stack executor: one primitive per transaction on a 64-cell stack
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall carry i_func and i_literal; a transaction
//   is taken when i_valid is high and o_stall is low
// output channel: o_valid / i_stall carry status, printed output, depth and
//   the new top of stack, one result per input transaction
// sequence: operand reads, execute, write-back, top of stack read, result
//   load; div and mod with a nonzero divisor wait on the bit-serial divider
// throughput: one transaction in flight; ops read at most 3 cells and write
//   at most 3 through the single-read, single-write stack memory
// the result sits in an output register, so a stalled receiver only holds
//   the block once the next result is ready to load
// reset (synchronous, active low) empties the stack and drops any pending
//   result; stack memory contents are not cleared
// ----------------------------------------------------------------------------
module stack_machine_word_executor (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [smwe_pkg::FUNC_W-1:0]           i_func,
    input  logic signed [smwe_pkg::FIELD_BITS-1:0] i_literal,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [1:0]                            o_status,
    output logic [1:0]                            o_out_kind,
    output logic signed [smwe_pkg::FIELD_BITS-1:0] o_out_value,
    output logic [smwe_pkg::SP_W-1:0]             o_depth,
    output logic signed [smwe_pkg::FIELD_BITS-1:0] o_top_value
);
    import smwe_pkg::*;

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer owns both handshakes
    smwe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // datapath holds the stack, the alu, the divider and the result register
    smwe_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_func      (i_func),
        .i_literal   (i_literal),
        .o_status    (o_status),
        .o_out_kind  (o_out_kind),
        .o_out_value (o_out_value),
        .o_depth     (o_depth),
        .o_top_value (o_top_value)
    );

endmodule
